### hdl/dis_pkg.sv
// Package for the disjoint interval set: sizes, status codes, cell control types.
package dis_pkg;

  localparam int MAX_INTERVALS = 32;
  localparam int VALUE_BITS    = 30;
  localparam int FIELD_W       = 30;
  localparam int CNT_W         = $clog2(MAX_INTERVALS + 1);

  localparam logic [FIELD_W-1:0] VAL_MASK = FIELD_W'((64'd1 << VALUE_BITS) - 64'd1);

  localparam logic [2:0] ST_ADDED   = 3'd0;
  localparam logic [2:0] ST_PRESENT = 3'd1;
  localparam logic [2:0] ST_FULL    = 3'd2;
  localparam logic [2:0] ST_ENTRY   = 3'd3;
  localparam logic [2:0] ST_EMPTY   = 3'd4;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_CMP,
    OP_MERGE_BOTH,
    OP_SET_END,
    OP_SET_START,
    OP_INSERT,
    OP_ROTATE
  } cell_op_t;

  typedef struct packed {
    cell_op_t           op;
    logic [FIELD_W-1:0] v;
  } cell_ctl_t;

  typedef struct packed {
    logic pres;
    logic jp;
    logic jn;
  } cell_flags_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_UPD,
    S_RD
  } state_t;

endpackage

### hdl/dis_cell.sv
// One table slot: holds an interval, compares it with the broadcast value, shifts with neighbors.
module dis_cell (
  input  logic                        clk,
  input  logic                        rst,
  input  dis_pkg::cell_ctl_t          ctl,
  input  logic                        valid,
  input  logic                        tail,
  input  logic                        left_le_c,
  input  logic                        left_le_r,
  input  logic                        right_le_c,
  input  logic [dis_pkg::FIELD_W-1:0] left_start,
  input  logic [dis_pkg::FIELD_W-1:0] left_end,
  input  logic [dis_pkg::FIELD_W-1:0] right_start,
  input  logic [dis_pkg::FIELD_W-1:0] right_end,
  input  logic [dis_pkg::FIELD_W-1:0] wrap_start,
  input  logic [dis_pkg::FIELD_W-1:0] wrap_end,
  output logic [dis_pkg::FIELD_W-1:0] start_q,
  output logic [dis_pkg::FIELD_W-1:0] end_q,
  output logic                        le_c,
  output logic                        le_r,
  output dis_pkg::cell_flags_t        flags
);

  logic prev_r;
  logic next_r;
  logic prev_c;
  logic next_c;
  logic ins_at;
  logic [dis_pkg::FIELD_W:0] end_inc;
  logic [dis_pkg::FIELD_W:0] v_inc;

  assign le_c    = valid && (start_q <= ctl.v);
  assign prev_c  = le_c && !right_le_c;
  assign next_c  = valid && !le_c && left_le_c;
  assign end_inc = {1'b0, end_q} + (dis_pkg::FIELD_W+1)'(1);
  assign v_inc   = {1'b0, ctl.v} + (dis_pkg::FIELD_W+1)'(1);
  // insertion point: first slot past the last start not above the value
  assign ins_at  = !le_r && left_le_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      le_r   <= 1'b0;
      prev_r <= 1'b0;
      next_r <= 1'b0;
      flags  <= '0;
    end else if (ctl.op == dis_pkg::OP_CMP) begin
      le_r       <= le_c;
      prev_r     <= prev_c;
      next_r     <= next_c;
      flags.pres <= prev_c && (end_q >= ctl.v);
      flags.jp   <= prev_c && (end_inc == {1'b0, ctl.v});
      flags.jn   <= next_c && (v_inc == {1'b0, start_q});
    end
  end

  always_ff @(posedge clk) begin
    case (ctl.op)
      dis_pkg::OP_MERGE_BOTH: begin
        if (prev_r) begin
          end_q <= right_end;
        end else if (!le_r) begin
          start_q <= right_start;
          end_q   <= right_end;
        end
      end
      dis_pkg::OP_SET_END: begin
        if (prev_r) begin
          end_q <= ctl.v;
        end
      end
      dis_pkg::OP_SET_START: begin
        if (next_r) begin
          start_q <= ctl.v;
        end
      end
      dis_pkg::OP_INSERT: begin
        if (ins_at) begin
          start_q <= ctl.v;
          end_q   <= ctl.v;
        end else if (!le_r) begin
          start_q <= left_start;
          end_q   <= left_end;
        end
      end
      dis_pkg::OP_ROTATE: begin
        if (tail) begin
          start_q <= wrap_start;
          end_q   <= wrap_end;
        end else begin
          start_q <= right_start;
          end_q   <= right_end;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

### hdl/disjoint_interval_set_core.sv
// Top level of the disjoint interval set: control sequencer over a chain of interval cells.
//
//  channel   signals                                   direction  handshake
//  command   start, busy, mode, value                  in         taken when start & !busy
//  result    result_valid, status, range_low,          out        result_valid strobe,
//            range_high, last                                     no back-pressure
//
// An add goes through a compare cycle, in which every cell compares its interval with
// the value, and then an update cycle, in which the cells merge, shift or insert. busy
// is high only in the compare cycle, so the next add can be taken in the update cycle;
// the status appears the cycle after the update edge. A readout rotates the chain once
// per stored interval with busy high throughout; an empty table answers in the cycle
// after the item is taken and never raises busy.
// Reset clears the entry count and the sequencer; stored intervals are left as is.
// The receiver cannot stall: each result is shown for exactly one cycle.
module disjoint_interval_set_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic                        mode,
  input  logic [dis_pkg::FIELD_W-1:0] value,
  output logic                        result_valid,
  output logic [2:0]                  status,
  output logic [dis_pkg::FIELD_W-1:0] range_low,
  output logic [dis_pkg::FIELD_W-1:0] range_high,
  output logic                        last
);

  localparam int N  = dis_pkg::MAX_INTERVALS;
  localparam int FW = dis_pkg::FIELD_W;
  localparam int CW = dis_pkg::CNT_W;

  dis_pkg::state_t    state;
  dis_pkg::state_t    state_next;
  logic [CW-1:0]      count;
  logic [CW-1:0]      count_next;
  logic [CW-1:0]      rd_idx;
  logic [CW-1:0]      rd_idx_next;
  logic [FW-1:0]      val_r;
  dis_pkg::cell_ctl_t ctl;
  logic               accept;
  logic               rd_done;
  logic               full;

  // result register feed
  logic               emit;
  logic [2:0]         emit_status;
  logic [FW-1:0]      emit_low;
  logic [FW-1:0]      emit_high;
  logic               emit_last;

  // chain wiring
  logic [FW-1:0]        c_start [N];
  logic [FW-1:0]        c_end   [N];
  logic [N-1:0]         c_le_c;
  logic [N-1:0]         c_le_r;
  logic [N-1:0]         c_pres;
  logic [N-1:0]         c_jp;
  logic [N-1:0]         c_jn;
  dis_pkg::cell_flags_t c_flags [N];

  logic any_pres;
  logic any_jp;
  logic any_jn;

  genvar gi;
  generate
    for (gi = 0; gi < N; gi++) begin : g_cell
      logic          valid_i;
      logic          tail_i;
      logic          l_le_c;
      logic          l_le_r;
      logic          r_le_c;
      logic [FW-1:0] l_start;
      logic [FW-1:0] l_end;
      logic [FW-1:0] r_start;
      logic [FW-1:0] r_end;

      assign valid_i = CW'(gi) < count;
      assign tail_i  = CW'(gi + 1) == count;

      if (gi == 0) begin : g_first
        // nothing below slot zero: it is always past every lower start
        assign l_le_c  = 1'b1;
        assign l_le_r  = 1'b1;
        assign l_start = '0;
        assign l_end   = '0;
      end else begin : g_mid_l
        assign l_le_c  = c_le_c[gi-1];
        assign l_le_r  = c_le_r[gi-1];
        assign l_start = c_start[gi-1];
        assign l_end   = c_end[gi-1];
      end

      if (gi == N - 1) begin : g_last
        assign r_le_c  = 1'b0;
        assign r_start = '0;
        assign r_end   = '0;
      end else begin : g_mid_r
        assign r_le_c  = c_le_c[gi+1];
        assign r_start = c_start[gi+1];
        assign r_end   = c_end[gi+1];
      end

      dis_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .ctl        (ctl),
        .valid      (valid_i),
        .tail       (tail_i),
        .left_le_c  (l_le_c),
        .left_le_r  (l_le_r),
        .right_le_c (r_le_c),
        .left_start (l_start),
        .left_end   (l_end),
        .right_start(r_start),
        .right_end  (r_end),
        .wrap_start (c_start[0]),
        .wrap_end   (c_end[0]),
        .start_q    (c_start[gi]),
        .end_q      (c_end[gi]),
        .le_c       (c_le_c[gi]),
        .le_r       (c_le_r[gi]),
        .flags      (c_flags[gi])
      );

      assign c_pres[gi] = c_flags[gi].pres;
      assign c_jp[gi]   = c_flags[gi].jp;
      assign c_jn[gi]   = c_flags[gi].jn;
    end
  endgenerate

  assign any_pres = |c_pres;
  assign any_jp   = |c_jp;
  assign any_jn   = |c_jn;
  assign full     = count == CW'(N);

  // Busy while comparing or reading out; the update cycle already takes the next item.
  assign busy    = (state == dis_pkg::S_CMP) || (state == dis_pkg::S_RD);
  assign accept  = start && !busy;
  assign rd_done = rd_idx == (count - CW'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= dis_pkg::S_IDLE;
      count        <= '0;
      rd_idx       <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      count        <= count_next;
      rd_idx       <= rd_idx_next;
      result_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      val_r <= value & dis_pkg::VAL_MASK;
    end
    if (emit) begin
      status     <= emit_status;
      range_low  <= emit_low;
      range_high <= emit_high;
      last       <= emit_last;
    end
  end

  always_comb begin
    state_next  = state;
    count_next  = count;
    rd_idx_next = rd_idx;
    ctl.op      = dis_pkg::OP_HOLD;
    ctl.v       = val_r;
    emit        = 1'b0;
    emit_status = dis_pkg::ST_ADDED;
    emit_low    = '0;
    emit_high   = '0;
    emit_last   = 1'b1;

    case (state)
      dis_pkg::S_CMP: begin
        ctl.op     = dis_pkg::OP_CMP;
        state_next = dis_pkg::S_UPD;
      end
      dis_pkg::S_UPD: begin
        emit = 1'b1;
        if (any_pres) begin
          emit_status = dis_pkg::ST_PRESENT;
        end else if (any_jp && any_jn) begin
          ctl.op     = dis_pkg::OP_MERGE_BOTH;
          count_next = count - CW'(1);
        end else if (any_jp) begin
          ctl.op = dis_pkg::OP_SET_END;
        end else if (any_jn) begin
          ctl.op = dis_pkg::OP_SET_START;
        end else if (full) begin
          emit_status = dis_pkg::ST_FULL;
        end else begin
          ctl.op     = dis_pkg::OP_INSERT;
          count_next = count + CW'(1);
        end
        state_next = dis_pkg::S_IDLE;
      end
      dis_pkg::S_RD: begin
        // slot zero goes out, the valid part of the chain turns by one
        ctl.op      = dis_pkg::OP_ROTATE;
        emit        = 1'b1;
        emit_status = dis_pkg::ST_ENTRY;
        emit_low    = c_start[0];
        emit_high   = c_end[0];
        emit_last   = rd_done;
        rd_idx_next = rd_idx + CW'(1);
        if (rd_done) begin
          state_next = dis_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = dis_pkg::S_IDLE;
      end
    endcase

    // a new item enters from idle or alongside the update cycle
    if (accept) begin
      if (!mode) begin
        state_next = dis_pkg::S_CMP;
      end else if (count_next == '0) begin
        emit        = 1'b1;
        emit_status = dis_pkg::ST_EMPTY;
        emit_last   = 1'b1;
        state_next  = dis_pkg::S_IDLE;
      end else begin
        rd_idx_next = '0;
        state_next  = dis_pkg::S_RD;
      end
    end
  end

  // An empty readout never lands on the update cycle's emit: every add leaves at
  // least one entry behind, so count_next is nonzero whenever an update is running.

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(N))
    else $error("entry count above table size");

  a_full_drop: assert property (@(posedge clk) disable iff (rst)
    (result_valid && status == dis_pkg::ST_FULL) |-> count == CW'(N))
    else $error("value dropped while table had room");

  a_entry_order: assert property (@(posedge clk) disable iff (rst)
    (result_valid && status == dis_pkg::ST_ENTRY) |-> range_low <= range_high)
    else $error("interval read out with start above end");

  a_readout_keeps: assert property (@(posedge clk) disable iff (rst)
    (state == dis_pkg::S_RD) |=> $stable(count))
    else $error("entry count changed during readout");

endmodule

### tb/tb_disjoint_interval_set_core.sv
// Testbench for disjoint_interval_set_core: random add/readout items checked against a table model.
module tb_disjoint_interval_set_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 2000;  // cycles with no item taken
  localparam int TAIL_CYCLES = 40;    // longest readout plus margin
  localparam int ITEM_TARGET = 262;

  localparam logic MODE_ADD  = 1'b0;
  localparam logic MODE_READ = 1'b1;

  localparam logic [dis_pkg::FIELD_W-1:0] VMAX = dis_pkg::VAL_MASK;

  // One pending command. A hold entry is not an item: it stops the driver
  // until every expected result has come back.
  typedef struct {
    bit                          hold;
    bit                          steady;   // no random gap before this item
    logic                        mode;
    logic [dis_pkg::FIELD_W-1:0] val;
  } cmd_t;

  typedef struct {
    logic [2:0]                  status;
    logic [dis_pkg::FIELD_W-1:0] lo;
    logic [dis_pkg::FIELD_W-1:0] hi;
    logic                        last;
  } result_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        start = 1'b0;
  logic                        mode = MODE_ADD;
  logic [dis_pkg::FIELD_W-1:0] value = '0;
  logic                        busy;
  logic                        result_valid;
  logic [2:0]                  status;
  logic [dis_pkg::FIELD_W-1:0] range_low;
  logic [dis_pkg::FIELD_W-1:0] range_high;
  logic                        last;

  cmd_t    cmd_q[$];
  result_t due_q[$];       // results owed by accepted items, oldest first
  bit      drained = 1'b0; // registered: nothing owed after the last edge
  int      errors = 0;
  int      stall_cnt = 0;
  bit      gapless = 1'b0;

  // Our own copy of the interval table
  logic [dis_pkg::FIELD_W-1:0] ivl_lo[dis_pkg::MAX_INTERVALS];
  logic [dis_pkg::FIELD_W-1:0] ivl_hi[dis_pkg::MAX_INTERVALS];
  int                          ivl_n = 0;

  disjoint_interval_set_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .mode         (mode),
    .value        (value),
    .result_valid (result_valid),
    .status       (status),
    .range_low    (range_low),
    .range_high   (range_high),
    .last         (last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Append one owed result / one pending command
  task automatic owe_one(input result_t r);
    due_q = {due_q, r};
  endtask

  task automatic queue_cmd(input cmd_t c);
    cmd_q = {cmd_q, c};
  endtask

  // ---------------------------------------------------------------------
  // Table model: add a value, return the status
  // ---------------------------------------------------------------------
  task automatic ivl_add(input logic [dis_pkg::FIELD_W-1:0] v, output logic [2:0] st);
    int pos;
    bit has_prev, has_next, jp, jn;
    pos = 0;
    // pos = first entry that starts above v; prev is pos-1, next is pos
    while (pos < ivl_n && ivl_lo[pos] <= v) pos++;
    has_prev = pos > 0;
    has_next = pos < ivl_n;
    st = dis_pkg::ST_ADDED;
    if (has_prev && ivl_hi[pos-1] >= v) begin
      st = dis_pkg::ST_PRESENT;
      return;
    end
    // +1 at 31 bits so the top value never wraps
    jp = has_prev && ({1'b0, ivl_hi[pos-1]} + 31'd1 == {1'b0, v});
    jn = has_next && ({1'b0, v} + 31'd1 == {1'b0, ivl_lo[pos]});
    if (jp && jn) begin
      // value bridges prev and next: fold next into prev, close the hole
      ivl_hi[pos-1] = ivl_hi[pos];
      for (int i = pos; i + 1 < ivl_n; i++) begin
        ivl_lo[i] = ivl_lo[i+1];
        ivl_hi[i] = ivl_hi[i+1];
      end
      ivl_n--;
    end else if (jp) begin
      ivl_hi[pos-1] = v;
    end else if (jn) begin
      ivl_lo[pos] = v;
    end else if (ivl_n >= dis_pkg::MAX_INTERVALS) begin
      st = dis_pkg::ST_FULL;  // needs a new entry and there is no room
    end else begin
      for (int i = ivl_n; i > pos; i--) begin
        ivl_lo[i] = ivl_lo[i-1];
        ivl_hi[i] = ivl_hi[i-1];
      end
      ivl_lo[pos] = v;
      ivl_hi[pos] = v;
      ivl_n++;
    end
  endtask

  // Queue up what the block owes for one accepted item
  task automatic owe_results(input logic m, input logic [dis_pkg::FIELD_W-1:0] v);
    result_t r;
    logic [2:0] st;
    if (m == MODE_ADD) begin
      ivl_add(v & dis_pkg::VAL_MASK, st);
      r = '{status: st, lo: '0, hi: '0, last: 1'b1};
      owe_one(r);
    end else if (ivl_n == 0) begin
      r = '{status: dis_pkg::ST_EMPTY, lo: '0, hi: '0, last: 1'b1};
      owe_one(r);
    end else begin
      for (int i = 0; i < ivl_n; i++) begin
        r = '{status: dis_pkg::ST_ENTRY, lo: ivl_lo[i], hi: ivl_hi[i],
              last: (i == ivl_n - 1)};
        owe_one(r);
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Driver: presents the head of cmd_q whenever the previous item is gone
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    cmd_t nxt;
    if (rst) begin
      start <= 1'b0;
      mode  <= MODE_ADD;
      value <= '0;
    end else if (!start || !busy) begin
      // either nothing was offered or the offered item is taken at this edge
      if (cmd_q.size() == 0) begin
        start <= 1'b0;
      end else if (cmd_q[0].hold) begin
        // drained is only trusted once start is already low,
        // so it already accounts for the last item taken
        start <= 1'b0;
        if (!start && drained) void'(cmd_q.pop_front());
      end else if (!cmd_q[0].steady && $urandom_range(0, 99) < 29) begin
        start <= 1'b0;
      end else begin
        nxt = cmd_q.pop_front();
        start <= 1'b1;
        mode  <= nxt.mode;
        value <= nxt.val;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: check results first, then predict for the item taken now.
  // Results are registered and come after acceptance, so this order is safe.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      ivl_n = 0;
      due_q.delete();
      drained <= 1'b1;
    end else begin
      if (result_valid) begin
        if (due_q.size() == 0) begin
          $display("%0t: unexpected result status=%0d low=%0h high=%0h last=%0b",
                   $time, status, range_low, range_high, last);
          errors++;
        end else begin
          want = due_q.pop_front();
          if (status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, status);
            errors++;
          end
          if (range_low !== want.lo) begin
            $display("%0t: range_low expected %0h actual %0h", $time, want.lo, range_low);
            errors++;
          end
          if (range_high !== want.hi) begin
            $display("%0t: range_high expected %0h actual %0h", $time, want.hi, range_high);
            errors++;
          end
          if (last !== want.last) begin
            $display("%0t: last expected %0b actual %0b", $time, want.last, last);
            errors++;
          end
        end
      end
      if (start && !busy) owe_results(mode, value);
      drained <= (due_q.size() == 0);
    end
  end

  // Watchdog: only a taken item counts as progress
  always @(posedge clk) begin
    if (rst || (start && !busy)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_LIMIT) begin
      $display("%0t: no item taken for %0d cycles", $time, STALL_LIMIT);
      $display("tb_disjoint_interval_set_core: done, errors");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  task automatic add_cmd(input logic [dis_pkg::FIELD_W-1:0] v);
    queue_cmd('{hold: 1'b0, steady: gapless, mode: MODE_ADD, val: v});
  endtask

  // value is don't-care in readout mode, so it gets random bits
  task automatic read_cmd();
    queue_cmd('{hold: 1'b0, steady: gapless, mode: MODE_READ,
                val: dis_pkg::FIELD_W'($urandom) & dis_pkg::VAL_MASK});
  endtask

  task automatic hold_cmd();
    queue_cmd('{hold: 1'b1, steady: 1'b0, mode: MODE_ADD, val: '0});
  endtask

  // base + off, clamped to the top of the value range
  function automatic logic [dis_pkg::FIELD_W-1:0] near(
    input logic [dis_pkg::FIELD_W-1:0] base, input int off);
    logic [dis_pkg::FIELD_W:0] sum;
    sum = {1'b0, base} + (dis_pkg::FIELD_W+1)'(off);
    return (sum > {1'b0, VMAX}) ? VMAX : sum[dis_pkg::FIELD_W-1:0];
  endfunction

  function automatic logic [dis_pkg::FIELD_W-1:0] pick_base();
    case ($urandom_range(0, 5))
      0:       return dis_pkg::FIELD_W'($urandom_range(0, 20));
      1:       return VMAX - dis_pkg::FIELD_W'($urandom_range(0, 60));
      default: return dis_pkg::FIELD_W'($urandom) & dis_pkg::VAL_MASK;
    endcase
  endfunction

  // Isolated points two apart, then the gaps: the gaps merge neighbors,
  // even when the table is full
  task automatic comb(input logic [dis_pkg::FIELD_W-1:0] base, input int teeth);
    for (int k = 0; k < teeth; k++) begin
      add_cmd(near(base, 2 * k));
      if ($urandom_range(0, 7) == 0) read_cmd();
    end
    for (int k = 0; k < teeth; k++) begin
      add_cmd(near(base, 2 * k + 1));
      if ($urandom_range(0, 7) == 0) read_cmd();
    end
    read_cmd();
  endtask

  initial begin
    logic [dis_pkg::FIELD_W-1:0] base;
    logic [dis_pkg::FIELD_W-1:0] bases[$];
    int kind, w, n;
    bit mid_done;
    mid_done = 1'b0;

    // Directed: empty readout, both ends of the range, every merge kind
    read_cmd();                                 // empty table
    add_cmd(VMAX);                              // no next neighbor, top value
    add_cmd(VMAX);                              // already present
    add_cmd(VMAX - dis_pkg::FIELD_W'(1));       // joins the interval just above
    add_cmd(VMAX - dis_pkg::FIELD_W'(3));       // new point
    add_cmd(VMAX - dis_pkg::FIELD_W'(2));       // bridges both neighbors
    add_cmd('0);                                // no prev neighbor
    add_cmd(30'd1);                             // joins the interval just below
    add_cmd(30'd3);
    add_cmd(30'd2);                             // bridges both
    add_cmd('0);                                // inside an interval
    add_cmd(30'h2AAAAAAA);
    add_cmd(30'h15555555);
    add_cmd(30'h15555556);
    add_cmd(30'h15555554);
    read_cmd();
    hold_cmd();                                 // sender waits for the table to settle

    // Fill past capacity first so full drops and merges-while-full show up
    base = dis_pkg::FIELD_W'($urandom) & dis_pkg::VAL_MASK;
    bases = {bases, base};
    comb(base, 36);

    while (cmd_q.size() < ITEM_TARGET) begin
      if (!mid_done && cmd_q.size() >= 120) begin
        hold_cmd();
        gapless = 1'b1;         // back-to-back items for a while
        mid_done = 1'b1;
      end
      if (gapless && cmd_q.size() >= 180) gapless = 1'b0;

      // revisiting old windows lets gaps close and frees table room
      if (bases.size() > 0 && $urandom_range(0, 1)) begin
        base = bases[$urandom_range(0, bases.size() - 1)];
      end else begin
        base = pick_base();
        bases = {bases, base};
      end

      kind = $urandom_range(0, 9);
      if (kind < 5) begin
        w = $urandom_range(3, 40);
        n = $urandom_range(5, 16);
        repeat (n) begin
          if ($urandom_range(0, 7) == 0) read_cmd();
          else add_cmd(near(base, $urandom_range(0, w)));
        end
      end else if (kind < 7) begin
        comb(base, $urandom_range(4, 12));
      end else if (kind < 9) begin
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(0, 3) == 0) read_cmd();
          else add_cmd(dis_pkg::FIELD_W'($urandom) & dis_pkg::VAL_MASK);
        end
      end else begin
        read_cmd();
      end
    end
    read_cmd();

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // sample at the falling edge so every register update has landed
    while (cmd_q.size() != 0 || start || due_q.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("tb_disjoint_interval_set_core: done, clean");
    end else begin
      $display("tb_disjoint_interval_set_core: done, errors");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/dis_pkg.sv
hdl/dis_cell.sv
hdl/disjoint_interval_set_core.sv
tb/tb_disjoint_interval_set_core.sv
